// File: rtl/urlf_pkg.sv
// ----------------------------------------------------------------------------
// urlf_pkg
// Shared types, constants and helper functions of the receive line buffer.
// ----------------------------------------------------------------------------
package urlf_pkg;

    // Ring size and the largest read of one command.
    localparam int DEPTH    = 256;
    localparam int MAX_READ = 64;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(MAX_READ + 1);

    // Line terminators.
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [PTR_W:0]   t_ptr_x;
    typedef logic [CNT_W-1:0] t_cnt;

    // Command codes carried by an input item.
    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_LINE = 2'd1,
        CMD_RAW  = 2'd2
    } t_cmd;

    // Payload of one input item.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic [6:0] max_len;
        logic [6:0] read_count;
    } t_in_item;

    // Payload of one result item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
        logic [6:0] length;
        logic       dropped;
        logic [7:0] fill_level;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic push;
        logic line_init;
        logic raw_init;
        logic scan_rd;
        logic scan_ev;
        logic scan_done;
        logic deliv_rd;
        logic deliv_ev;
        logic load_empty;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       line_ok;
        logic       raw_zero;
        logic       scan_empty;
        logic       scan_stop;
        logic       n_zero;
        logic       deliv_last;
    } t_dp_sts;

    // Advance a ring pointer by one slot with wrap.
    function automatic t_ptr next_slot(input t_ptr p);
        return (p == t_ptr'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // True for CR or LF.
    function automatic logic is_term(input logic [7:0] b);
        return (b == CHAR_CR) || (b == CHAR_LF);
    endfunction

endpackage

// File: rtl/urlf_if.sv
// ----------------------------------------------------------------------------
// urlf_in_if / urlf_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface urlf_in_if;
    logic                valid;
    logic                ready;
    urlf_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface urlf_out_if;
    logic                valid;
    logic                ready;
    urlf_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/uart_rx_line_fifo.sv
// ----------------------------------------------------------------------------
// uart_rx_line_fifo
// Receive byte ring buffer with a line reader and a raw byte reader.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on i_in: push stores rx_byte (or flags it dropped when
// the ring is full), read line pops one CR/LF terminated line, read bytes
// pops up to read_count raw bytes. Results leave on o_out, one per popped
// byte, or a single empty result; last marks the final one, which carries
// length and dropped. fill_level is the level after the whole command.
// Sequence: a push, or a read answered at once with an empty result, passes
// through the execute state and loads its result before the next item is
// taken. A raw read sets up, then reads and delivers one byte at a time. A
// line read decodes, scans with a read and an evaluate step per byte
// examined, closes the scan, then delivers with a read and a load per byte.
// One command is handled at a time; i_in.ready is high only while idle.
// The last result stays in the output register while the next item is taken.
// Reset empties the ring and clears the terminator count; the byte store is
// not cleared. A stalled receiver holds the result and stops the sequencer.
// ----------------------------------------------------------------------------
module uart_rx_line_fifo (
    input  logic       i_clk,
    input  logic       i_rst_n,
    urlf_in_if.sink    i_in,
    urlf_out_if.source o_out
);

    urlf_pkg::t_dp_ctl w_ctl;
    urlf_pkg::t_dp_sts w_sts;

    // Sequencer.
    urlf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    // Ring, walkers and result register.
    urlf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .i_in_item  (i_in.data),
        .o_out_item (o_out.data)
    );

endmodule

// File: rtl/urlf_ram.sv
// ----------------------------------------------------------------------------
// urlf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module urlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds while not enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/urlf_dp.sv
// ----------------------------------------------------------------------------
// urlf_dp
// Datapath: ring pointers, terminator count, scan and delivery walkers,
// byte store and the result register.
// ----------------------------------------------------------------------------
module urlf_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  urlf_pkg::t_dp_ctl   i_ctl,
    output urlf_pkg::t_dp_sts   o_sts,
    input  urlf_pkg::t_in_item  i_in_item,
    output urlf_pkg::t_out_item o_out_item
);

    // Persistent ring state.
    urlf_pkg::t_ptr      r_rp;
    urlf_pkg::t_ptr      r_wp;
    urlf_pkg::t_ptr      r_tc;

    // Per-item working registers.
    urlf_pkg::t_in_item  r_item;
    logic                r_dropped;
    urlf_pkg::t_ptr      r_walk;
    urlf_pkg::t_ptr      r_start;
    urlf_pkg::t_ptr      r_cons;
    urlf_pkg::t_cnt      r_n;
    urlf_pkg::t_cnt      r_k;
    urlf_pkg::t_out_item r_out;

    logic                w_full;
    urlf_pkg::t_ptr      w_fill;
    urlf_pkg::t_cnt      w_mlen;
    urlf_pkg::t_cnt      w_rcnt;
    urlf_pkg::t_cnt      w_raw_n;
    urlf_pkg::t_ptr_x    w_sum;
    urlf_pkg::t_ptr      w_raw_end;
    logic [7:0]          w_rdata;
    logic                w_rd_term;

    // Byte store.
    urlf_ram #(
        .WIDTH (8),
        .DEPTH (urlf_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push && !w_full),
        .i_waddr (r_wp),
        .i_wdata (r_item.rx_byte),
        .i_re    (i_ctl.scan_rd || i_ctl.deliv_rd),
        .i_raddr (r_walk),
        .o_rdata (w_rdata)
    );

    // Fill level, clamped lengths and the end pointer of a raw read.
    always_comb begin
        w_full = (urlf_pkg::next_slot(r_wp) == r_rp);
        if (r_wp >= r_rp) begin
            w_fill = r_wp - r_rp;
        end else begin
            w_fill = urlf_pkg::t_ptr'(urlf_pkg::t_ptr_x'(urlf_pkg::DEPTH)
                     - urlf_pkg::t_ptr_x'(r_rp) + urlf_pkg::t_ptr_x'(r_wp));
        end
        w_mlen = (r_item.max_len > 7'(urlf_pkg::MAX_READ))
                 ? urlf_pkg::t_cnt'(urlf_pkg::MAX_READ)
                 : urlf_pkg::t_cnt'(r_item.max_len);
        w_rcnt = (r_item.read_count > 7'(urlf_pkg::MAX_READ))
                 ? urlf_pkg::t_cnt'(urlf_pkg::MAX_READ)
                 : urlf_pkg::t_cnt'(r_item.read_count);
        if (32'(w_fill) < 32'(w_rcnt)) begin
            w_raw_n = urlf_pkg::t_cnt'(w_fill);
        end else begin
            w_raw_n = w_rcnt;
        end
        w_sum = urlf_pkg::t_ptr_x'(r_rp) + urlf_pkg::t_ptr_x'(w_raw_n);
        if (w_sum >= urlf_pkg::t_ptr_x'(urlf_pkg::DEPTH)) begin
            w_sum = w_sum - urlf_pkg::t_ptr_x'(urlf_pkg::DEPTH);
        end
        w_raw_end = urlf_pkg::t_ptr'(w_sum);
        w_rd_term = urlf_pkg::is_term(w_rdata);
    end

    // Status toward the controller.
    always_comb begin
        o_sts.cmd        = r_item.cmd;
        o_sts.line_ok    = (w_mlen >= urlf_pkg::t_cnt'(2)) && (r_tc != '0);
        o_sts.raw_zero   = (w_raw_n == '0);
        o_sts.scan_empty = (r_walk == r_wp);
        o_sts.scan_stop  = w_rd_term ? (r_n != '0)
                                     : ((r_n + 1'b1) == (w_mlen - 1'b1));
        o_sts.n_zero     = (r_n == '0);
        o_sts.deliv_last = ((r_k + 1'b1) == r_n);
    end

    // Ring pointers and terminator count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp <= '0;
            r_wp <= '0;
            r_tc <= '0;
        end else begin
            if (i_ctl.push && !w_full) begin
                r_wp <= urlf_pkg::next_slot(r_wp);
                if (urlf_pkg::is_term(r_item.rx_byte)) begin
                    r_tc <= r_tc + 1'b1;
                end
            end
            if (i_ctl.raw_init) begin
                r_rp <= w_raw_end;
            end
            if (i_ctl.scan_done) begin
                r_rp <= r_walk;
                r_tc <= r_tc - r_cons;
            end
            // Raw reads may pop terminators; line delivery never does.
            if (i_ctl.deliv_ev && w_rd_term && (r_tc != '0)) begin
                r_tc <= r_tc - 1'b1;
            end
        end
    end

    // Working registers and the result register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_item    <= i_in_item;
            r_dropped <= 1'b0;
        end
        if (i_ctl.push && w_full) begin
            r_dropped <= 1'b1;
        end
        if (i_ctl.line_init) begin
            r_walk  <= r_rp;
            r_start <= r_rp;
            r_n     <= '0;
            r_cons  <= '0;
        end
        if (i_ctl.raw_init) begin
            r_walk <= r_rp;
            r_n    <= w_raw_n;
            r_k    <= '0;
        end
        if (i_ctl.scan_rd || i_ctl.deliv_rd) begin
            r_walk <= urlf_pkg::next_slot(r_walk);
        end
        // A leading terminator moves the line start past itself.
        if (i_ctl.scan_ev) begin
            if (w_rd_term) begin
                r_cons <= r_cons + 1'b1;
                if (r_n == '0) begin
                    r_start <= r_walk;
                end
            end else begin
                r_n <= r_n + 1'b1;
            end
        end
        if (i_ctl.scan_done) begin
            r_walk <= r_start;
            r_k    <= '0;
        end
        if (i_ctl.deliv_ev) begin
            r_out.data_byte  <= w_rdata;
            r_out.byte_valid <= 1'b1;
            r_out.last       <= o_sts.deliv_last;
            r_out.length     <= o_sts.deliv_last ? 7'(r_n) : 7'd0;
            r_out.dropped    <= 1'b0;
            r_out.fill_level <= 8'(w_fill);
            r_k              <= r_k + 1'b1;
        end
        if (i_ctl.load_empty) begin
            r_out.data_byte  <= 8'd0;
            r_out.byte_valid <= 1'b0;
            r_out.last       <= 1'b1;
            r_out.length     <= 7'd0;
            r_out.dropped    <= r_dropped;
            r_out.fill_level <= 8'(w_fill);
        end
    end

    assign o_out_item = r_out;

endmodule

// File: rtl/urlf_ctrl.sv
// ----------------------------------------------------------------------------
// urlf_ctrl
// Controller: sequences push, line scan, delivery and result handshakes.
// ----------------------------------------------------------------------------
module urlf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  urlf_pkg::t_dp_sts i_sts,
    output urlf_pkg::t_dp_ctl o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EMPTY,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SCAN_DONE,
        S_DELIV_RD,
        S_DELIV_EV
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.cmd)
                    urlf_pkg::CMD_PUSH: begin
                        o_ctl.push = 1'b1;
                        n_state    = S_EMPTY;
                    end
                    urlf_pkg::CMD_LINE: begin
                        if (i_sts.line_ok) begin
                            o_ctl.line_init = 1'b1;
                            n_state         = S_SCAN_RD;
                        end else begin
                            n_state = S_EMPTY;
                        end
                    end
                    urlf_pkg::CMD_RAW: begin
                        o_ctl.raw_init = 1'b1;
                        n_state        = i_sts.raw_zero ? S_EMPTY : S_DELIV_RD;
                    end
                    default: begin
                        n_state = S_EMPTY;
                    end
                endcase
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    o_ctl.load_empty = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.scan_empty) begin
                    n_state = S_SCAN_DONE;
                end else begin
                    o_ctl.scan_rd = 1'b1;
                    n_state       = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                o_ctl.scan_ev = 1'b1;
                n_state       = i_sts.scan_stop ? S_SCAN_DONE : S_SCAN_RD;
            end
            S_SCAN_DONE: begin
                o_ctl.scan_done = 1'b1;
                n_state         = i_sts.n_zero ? S_EMPTY : S_DELIV_RD;
            end
            S_DELIV_RD: begin
                o_ctl.deliv_rd = 1'b1;
                n_state        = S_DELIV_EV;
            end
            S_DELIV_EV: begin
                if (w_out_free) begin
                    o_ctl.deliv_ev = 1'b1;
                    n_state        = i_sts.deliv_last ? S_IDLE : S_DELIV_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctl.load_empty || o_ctl.deliv_ev) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the receive line buffer. A queue of input items,
// first a directed set and then random lines, reads and noise, feeds a
// valid/ready driver. An internal copy of the ring, pointers and terminator
// count predicts every result when an item is accepted. The monitor checks
// results in order, field by field. Both sides insert random gaps, and once
// the receiver holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // The spare command code has no package name.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int RESET_CYCLES   = 6;
    localparam int MAX_GAP        = 6;
    localparam int HOLD_OFF       = 400;
    localparam int HOLD_AT_RESULT = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    urlf_in_if  in_ch ();
    urlf_out_if out_ch ();

    uart_rx_line_fifo dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Input items waiting to be driven and results still owed by the block.
    urlf_pkg::t_in_item  pending_q[$];
    urlf_pkg::t_out_item expected_results[$];

    // Predicted ring contents, pointers and count of held CR/LF bytes.
    logic [7:0] model_ring [urlf_pkg::DEPTH];
    int         model_rd    = 0;
    int         model_wr    = 0;
    int         model_terms = 0;

    int errors          = 0;
    int results_checked = 0;
    int idle_cycles     = 0;

    // Driver and receiver pacing state.
    int src_wait     = 0;
    bit src_steady   = 1'b0;
    int snk_wait     = 0;
    int snk_hold     = 0;
    bit snk_steady   = 1'b0;
    bit pressure_done = 1'b0;

    urlf_pkg::t_out_item got_item;
    urlf_pkg::t_out_item want_item;

    function automatic bit is_line_end(input logic [7:0] b);
        return (b == urlf_pkg::CHAR_CR) || (b == urlf_pkg::CHAR_LF);
    endfunction

    function automatic int ring_next(input int p);
        return (p + 1 >= urlf_pkg::DEPTH) ? 0 : p + 1;
    endfunction

    // Pop the oldest byte of the predicted ring; the caller checks it is not empty.
    function automatic logic [7:0] pop_model();
        logic [7:0] b;
        b = model_ring[model_rd];
        model_rd = ring_next(model_rd);
        if (is_line_end(b) && model_terms > 0)
            model_terms--;
        return b;
    endfunction

    // Apply one accepted item to the predicted ring and queue its results.
    task automatic predict_ring_step(input urlf_pkg::t_in_item it);
        int                  line_cap;
        int                  raw_cap;
        int                  level;
        logic [7:0]          b;
        logic                drop;
        logic [7:0]          popped[$];
        urlf_pkg::t_out_item r;
        line_cap = (it.max_len > urlf_pkg::MAX_READ) ? urlf_pkg::MAX_READ
                                                     : int'(it.max_len);
        raw_cap  = (it.read_count > urlf_pkg::MAX_READ) ? urlf_pkg::MAX_READ
                                                        : int'(it.read_count);
        drop     = 1'b0;
        case (it.cmd)
            urlf_pkg::CMD_PUSH: begin
                if (ring_next(model_wr) == model_rd) begin
                    drop = 1'b1;
                end else begin
                    model_ring[model_wr] = it.rx_byte;
                    model_wr = ring_next(model_wr);
                    if (is_line_end(it.rx_byte))
                        model_terms++;
                end
            end
            urlf_pkg::CMD_LINE: begin
                // Skip leading terminators, stop on the first later one.
                if (line_cap >= 2 && model_terms > 0) begin
                    while (popped.size() < line_cap - 1 && model_rd != model_wr) begin
                        b = pop_model();
                        if (is_line_end(b)) begin
                            if (popped.size() > 0)
                                break;
                        end else begin
                            popped.push_back(b);
                        end
                    end
                end
            end
            urlf_pkg::CMD_RAW: begin
                while (popped.size() < raw_cap && model_rd != model_wr)
                    popped.push_back(pop_model());
            end
            default: begin
            end
        endcase
        level = (model_wr >= model_rd) ? model_wr - model_rd
                                       : urlf_pkg::DEPTH - model_rd + model_wr;
        if (popped.size() == 0) begin
            r            = '0;
            r.last       = 1'b1;
            r.dropped    = drop;
            r.fill_level = level[7:0];
            expected_results.push_back(r);
        end else begin
            foreach (popped[i]) begin
                r            = '0;
                r.data_byte  = popped[i];
                r.byte_valid = 1'b1;
                r.fill_level = level[7:0];
                if (i == popped.size() - 1) begin
                    r.last    = 1'b1;
                    r.length  = 7'(popped.size());
                    r.dropped = drop;
                end
                expected_results.push_back(r);
            end
        end
    endtask

    task automatic queue_item(input logic [1:0] cmd, input logic [7:0] rx,
                              input logic [6:0] ml, input logic [6:0] rc);
        urlf_pkg::t_in_item it;
        it.cmd        = cmd;
        it.rx_byte    = rx;
        it.max_len    = ml;
        it.read_count = rc;
        pending_q.push_back(it);
    endtask

    // Push a line of random non-terminator bytes; ending 0 none, 1 CR, 2 LF, 3 CR LF.
    task automatic queue_line(input int len, input int ending);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            if (is_line_end(b))
                b = b ^ 8'h40;
            queue_item(urlf_pkg::CMD_PUSH, b, 7'($urandom), 7'($urandom));
        end
        if (ending == 1 || ending == 3)
            queue_item(urlf_pkg::CMD_PUSH, urlf_pkg::CHAR_CR, 7'($urandom), 7'($urandom));
        if (ending == 2 || ending == 3)
            queue_item(urlf_pkg::CMD_PUSH, urlf_pkg::CHAR_LF, 7'($urandom), 7'($urandom));
    endtask

    // One random item from the mix of lines, reads and noise; read_bias favors reads.
    task automatic queue_random_mix(input int read_bias);
        int sel;
        int cap;
        sel = $urandom_range(0, 99);
        if (sel < 45 - read_bias) begin
            queue_line(($urandom_range(0, 9) == 0) ? $urandom_range(50, 70)
                                                   : $urandom_range(0, 20),
                       $urandom_range(0, 3));
        end else if (sel < 72) begin
            cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                              : $urandom_range(2, 64);
            queue_item(urlf_pkg::CMD_LINE, 8'($urandom), 7'(cap), 7'($urandom));
        end else if (sel < 84) begin
            cap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                              : $urandom_range(0, 16);
            queue_item(urlf_pkg::CMD_RAW, 8'($urandom), 7'($urandom), 7'(cap));
        end else if (sel < 94) begin
            queue_item(urlf_pkg::CMD_PUSH, 8'($urandom), 7'($urandom), 7'($urandom));
        end else begin
            queue_item(2'($urandom), 8'($urandom), 7'($urandom), 7'($urandom));
        end
    endtask

    task automatic flag_mismatch(input string what);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR at result %0d: %s", results_checked, what);
    endtask

    // Driver: offer the next pending item after a random gap, hold until taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                predict_ring_step(in_ch.data);
            if (!in_ch.valid || in_ch.ready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    in_ch.valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= pending_q.pop_front();
                    if ($urandom_range(0, 29) == 0)
                        src_steady = !src_steady;
                    src_wait = src_steady ? 0 : $urandom_range(0, MAX_GAP);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest expectation and pace ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got_item = out_ch.data;
                if (expected_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result data %02h last %0d len %0d",
                                            got_item.data_byte, got_item.last,
                                            got_item.length));
                end else begin
                    want_item = expected_results.pop_front();
                    if (got_item.data_byte  !== want_item.data_byte  ||
                        got_item.byte_valid !== want_item.byte_valid ||
                        got_item.last       !== want_item.last       ||
                        got_item.length     !== want_item.length     ||
                        got_item.dropped    !== want_item.dropped    ||
                        got_item.fill_level !== want_item.fill_level)
                        flag_mismatch($sformatf({"expected data %02h valid %0d last %0d ",
                            "len %0d drop %0d fill %0d, got data %02h valid %0d last %0d ",
                            "len %0d drop %0d fill %0d"},
                            want_item.data_byte, want_item.byte_valid, want_item.last,
                            want_item.length, want_item.dropped, want_item.fill_level,
                            got_item.data_byte, got_item.byte_valid, got_item.last,
                            got_item.length, got_item.dropped, got_item.fill_level));
                end
                results_checked++;
                if ($urandom_range(0, 29) == 0)
                    snk_steady = !snk_steady;
                snk_wait = snk_steady ? 0 : $urandom_range(0, MAX_GAP);
                // Back the block up once while the driver keeps offering items.
                if (results_checked == HOLD_AT_RESULT && !pressure_done) begin
                    snk_hold      = HOLD_OFF;
                    pressure_done = 1'b1;
                end
            end
            if (snk_hold > 0) begin
                snk_hold--;
                out_ch.ready <= 1'b0;
            end else if (snk_wait > 0) begin
                snk_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int mark;
        i_rst_n = 1'b0;

        // Reads on an empty ring and the spare command code.
        queue_item(urlf_pkg::CMD_LINE, 8'h00, 7'd64, 7'd0);
        queue_item(urlf_pkg::CMD_RAW, 8'hFF, 7'd0, 7'd127);
        queue_item(CMD_SPARE, 8'hFF, 7'd127, 7'd127);
        // Data bytes including the extremes 00 and FF, followed by a CR.
        queue_item(urlf_pkg::CMD_PUSH, 8'h41, 7'd0, 7'd0);
        queue_item(urlf_pkg::CMD_PUSH, 8'h00, 7'd127, 7'd127);
        queue_item(urlf_pkg::CMD_PUSH, 8'hFF, 7'd0, 7'd0);
        queue_item(urlf_pkg::CMD_PUSH, urlf_pkg::CHAR_CR, 7'd0, 7'd0);
        // A line is held but the capacity leaves no room for data.
        queue_item(urlf_pkg::CMD_LINE, 8'h00, 7'd1, 7'd0);
        queue_item(urlf_pkg::CMD_LINE, 8'h00, 7'd0, 7'd0);
        // Capacity two gives one byte; an oversize capacity is clamped.
        queue_item(urlf_pkg::CMD_LINE, 8'h00, 7'd2, 7'd0);
        queue_item(urlf_pkg::CMD_LINE, 8'h00, 7'd127, 7'd0);
        // Leading terminators are dropped before the line body.
        queue_item(urlf_pkg::CMD_PUSH, urlf_pkg::CHAR_LF, 7'd0, 7'd0);
        queue_item(urlf_pkg::CMD_PUSH, urlf_pkg::CHAR_CR, 7'd0, 7'd0);
        queue_item(urlf_pkg::CMD_PUSH, 8'h78, 7'd0, 7'd0);
        queue_item(urlf_pkg::CMD_PUSH, urlf_pkg::CHAR_LF, 7'd0, 7'd0);
        queue_item(urlf_pkg::CMD_LINE, 8'h00, 7'd64, 7'd0);
        // A lone CR is consumed and the read still comes back empty.
        queue_item(urlf_pkg::CMD_PUSH, urlf_pkg::CHAR_CR, 7'd0, 7'd0);
        queue_item(urlf_pkg::CMD_LINE, 8'h00, 7'd64, 7'd0);
        // Raw reads of zero, two and an oversize count.
        queue_item(urlf_pkg::CMD_PUSH, 8'h61, 7'd0, 7'd0);
        queue_item(urlf_pkg::CMD_PUSH, 8'h62, 7'd0, 7'd0);
        queue_item(urlf_pkg::CMD_PUSH, 8'h63, 7'd0, 7'd0);
        queue_item(urlf_pkg::CMD_RAW, 8'h00, 7'd0, 7'd0);
        queue_item(urlf_pkg::CMD_RAW, 8'h00, 7'd0, 7'd2);
        queue_item(urlf_pkg::CMD_RAW, 8'h00, 7'd0, 7'd127);
        // A raw read takes the only terminator, so no line is left.
        queue_item(urlf_pkg::CMD_PUSH, urlf_pkg::CHAR_LF, 7'd0, 7'd0);
        queue_item(urlf_pkg::CMD_RAW, 8'h00, 7'd0, 7'd1);
        queue_item(urlf_pkg::CMD_LINE, 8'h00, 7'd64, 7'd0);

        // Mixed traffic with the ring mostly shallow.
        mark = pending_q.size();
        while (pending_q.size() - mark < 30)
            queue_random_mix(0);
        // Enough pushes to overflow the ring whatever it already holds.
        mark = pending_q.size();
        while (pending_q.size() - mark < 260)
            queue_line($urandom_range(0, 30), $urandom_range(0, 3));
        // Read-heavy traffic drains it again and wraps the pointers.
        mark = pending_q.size();
        while (pending_q.size() - mark < 30)
            queue_random_mix(30);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
